// ===== rtl/qstc_pkg.sv =====
package qstc_pkg;

    localparam int WORD_W     = 32;
    localparam int COMP_W     = 16;
    localparam int FIELD_BITS = 10;
    localparam int SIGN_POS   = 9;
    localparam int DATA_W     = WORD_W + 4 * COMP_W;

    localparam logic KIND_COMPRESS = 1'b0;
    localparam logic KIND_EXPAND   = 1'b1;

endpackage

// ===== rtl/quaternion_smallest_three_codec_unit.sv =====
// pipeline: stage a, stage b, stage c, the search stages and the output stage, each registered
// throughput: one beat per cycle; each stage holds one item and stalls only if the next is full
// every square root is a bit-serial search, one result bit per stage, which sets depth
// reset: aresetn low clears all stage valid bits on the next rising edge of aclk
module quaternion_smallest_three_codec_unit
    import qstc_pkg::*;
#(
    parameter int MAG_BITS            = 9,
    parameter int COMPONENT_FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // packed_in, comp_a, comp_b, comp_c, comp_d
    input  logic [DATA_W-1:0] s_tdata,
    // kind
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // packed_out, out_a, out_b, out_c, out_d
    output logic [DATA_W-1:0] m_tdata
);

    localparam int MB      = MAG_BITS;
    localparam int F       = COMPONENT_FRAC_BITS;
    localparam longint unsigned MAGMAX = longint'((1 << MB) - 1);
    localparam longint unsigned M2     = MAGMAX * MAGMAX;
    localparam int AW      = COMP_W;
    localparam int PW      = MB + AW;
    localparam int P8W     = 2 * PW + 3;
    localparam int TW      = 2 * (MB + 1) + 2 * F;
    localparam int CW      = ((P8W > TW) ? P8W : TW) + 1;
    localparam int XW      = 2 * MB + 2 * F + 2;
    localparam int QW      = XW + 2;
    localparam int SW      = F + 1;
    localparam int SMW     = F + 1 + 2 * MB;
    localparam int SQW     = 2 * MB + 2;
    localparam int NS      = F + 1;
    localparam int NT      = NS + 4;

    typedef struct packed {
        logic                             kind;
        logic [3:0][AW-1:0]               abs_v;
        logic [3:0]                       neg;
        logic [2:0][FIELD_BITS-1:0]       fld;
        logic [1:0]                       big_in;
    } sa_t;

    typedef struct packed {
        logic                             kind;
        logic [1:0]                       big;
        logic [2:0]                       sgn;
        logic [2:0][PW-1:0]               p;
        logic [2:0][MB-1:0]               emag;
    } sb_t;

    // root lanes 0 to 2 rebuild the small components, lane 3 the largest
    typedef struct packed {
        logic                             kind;
        logic [1:0]                       big;
        logic [2:0]                       sgn;
        logic [2:0][MB-1:0]               cmag;
        logic [2:0][P8W-1:0]              p8;
        logic [3:0][XW-1:0]               x;
        logic [3:0][SW-1:0]               s;
        logic [3:0][SMW-1:0]              sm;
        logic [3:0][XW-1:0]               s2m;
    } srch_t;

    logic [NT-1:0]   v_reg;
    logic [NT:0]     en;
    sa_t             a_reg, a_next;
    sb_t             b_reg, b_next;
    srch_t           srch_reg  [NS+1];
    srch_t           srch_next [NS+1];
    logic [DATA_W-1:0] out_reg, out_next;

    assign en[NT] = m_tready;
    generate
        for (genvar k = 0; k < NT; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NT-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NT; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage a: magnitudes and field split
    always_comb begin
        logic [COMP_W-1:0] q;
        a_next.kind   = s_tuser;
        for (int i = 0; i < 4; i++) begin
            q = s_tdata[WORD_W + COMP_W*i +: COMP_W];
            a_next.neg[i]   = q[COMP_W-1];
            a_next.abs_v[i] = q[COMP_W-1] ? AW'(-q) : q;
        end
        for (int l = 0; l < 3; l++) begin
            a_next.fld[l] = s_tdata[WORD_W-3-FIELD_BITS*l -: FIELD_BITS];
        end
        a_next.big_in = s_tdata[WORD_W-1 -: 2];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg <= a_next;
        end
    end

    // stage b: largest pick, scaling product, small magnitudes
    always_comb begin
        logic [1:0] bg;
        logic [1:0] idx;
        logic [MB-1:0] m;
        bg = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (a_reg.abs_v[i] > a_reg.abs_v[bg]) begin
                bg = 2'(i);
            end
        end
        if (a_reg.kind == KIND_EXPAND) begin
            bg = a_reg.big_in;
        end
        b_next.kind = a_reg.kind;
        b_next.big  = bg;
        for (int l = 0; l < 3; l++) begin
            idx = (2'(l) < bg) ? 2'(l) : 2'(l + 1);
            m   = a_reg.fld[l][MB-1:0];
            b_next.p[l]    = PW'(MAGMAX[MB-1:0]) * PW'(a_reg.abs_v[idx]);
            b_next.emag[l] = m;
            if (a_reg.kind == KIND_EXPAND) begin
                b_next.sgn[l] = a_reg.fld[l][SIGN_POS];
            end else begin
                b_next.sgn[l] = a_reg.neg[idx] ^ a_reg.neg[bg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            b_reg <= b_next;
        end
    end

    // stage c: squares, root targets for all four components
    always_comb begin
        logic [SQW-1:0] sumsq;
        logic [SQW-1:0] two_m2;
        logic [SQW-1:0] rem;
        logic [SQW-1:0] sq;
        sumsq  = '0;
        two_m2 = SQW'(M2) << 1;
        srch_next[0].kind = b_reg.kind;
        srch_next[0].big  = b_reg.big;
        srch_next[0].sgn  = b_reg.sgn;
        srch_next[0].cmag = '0;
        for (int l = 0; l < 3; l++) begin
            sq = SQW'(b_reg.emag[l]) * SQW'(b_reg.emag[l]);
            srch_next[0].p8[l] = P8W'(b_reg.p[l]) * P8W'(b_reg.p[l]) << 3;
            srch_next[0].x[l]  = XW'(sq) << (2 * F + 1);
            sumsq = sumsq + sq;
        end
        rem = (two_m2 > sumsq) ? two_m2 - sumsq : '0;
        srch_next[0].x[3] = XW'(rem) << (2 * F + 1);
        srch_next[0].s    = '0;
        srch_next[0].sm   = '0;
        srch_next[0].s2m  = '0;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            srch_reg[0] <= srch_next[0];
        end
    end

    // search stages: one root bit per lane per stage; the first MB stages also settle one magnitude bit per small lane
    generate
        for (genvar i = 0; i < NS; i++) begin : g_srch
            localparam int JE = F - i;
            always_comb begin
                logic [MB-1:0] cand;
                logic [MB:0]   u;
                logic [CW-1:0] t;
                logic [QW-1:0] c2m;
                srch_next[i+1] = srch_reg[i];
                if (i < MB) begin
                    for (int l = 0; l < 3; l++) begin
                        cand = srch_reg[i].cmag[l] | (MB'(1) << ((MB - 1 - i) % MB));
                        u    = {cand, 1'b0} - (MB+1)'(1);
                        t    = (CW'(u) * CW'(u)) << (2 * F);
                        if (t <= CW'(srch_reg[i].p8[l])) begin
                            srch_next[i+1].cmag[l] = cand;
                        end
                    end
                end
                for (int l = 0; l < 4; l++) begin
                    c2m = QW'(srch_reg[i].s2m[l]) + (QW'(srch_reg[i].sm[l]) << (JE + 1))
                        + (QW'(M2) << (2 * JE));
                    if (c2m <= QW'(srch_reg[i].x[l])) begin
                        srch_next[i+1].s[l]   = srch_reg[i].s[l] | (SW'(1) << JE);
                        srch_next[i+1].sm[l]  = srch_reg[i].sm[l] + (SMW'(M2) << JE);
                        srch_next[i+1].s2m[l] = c2m[XW-1:0];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en[3+i]) begin
                    srch_reg[i+1] <= srch_next[i+1];
                end
            end
        end
    endgenerate

    // output stage: word packing or component placement
    always_comb begin
        logic [WORD_W-1:0]         word;
        logic [FIELD_BITS-1:0]     fv;
        logic [3:0][COMP_W-1:0]    comp;
        logic [SW:0]               vw;
        logic [3:0][COMP_W-1:0]    rv;
        logic [1:0]                idx;
        srch_t                     r;
        r    = srch_reg[NS];
        word = WORD_W'(r.big);
        for (int l = 0; l < 3; l++) begin
            fv   = FIELD_BITS'(r.cmag[l]) | (FIELD_BITS'(r.sgn[l]) << SIGN_POS);
            word = (word << FIELD_BITS) | WORD_W'(fv);
        end
        for (int l = 0; l < 4; l++) begin
            vw    = ({1'b0, r.s[l]} + (SW+1)'(1)) >> 1;
            rv[l] = (32'(vw) > 32'd32767) ? COMP_W'(32767) : COMP_W'(vw);
        end
        comp = '0;
        comp[r.big] = rv[3];
        for (int l = 0; l < 3; l++) begin
            idx = (2'(l) < r.big) ? 2'(l) : 2'(l + 1);
            comp[idx] = r.sgn[l] ? COMP_W'(-rv[l]) : rv[l];
        end
        if (r.kind == KIND_EXPAND) begin
            out_next = {comp, {WORD_W{1'b0}}};
        end else begin
            out_next = {{(4*COMP_W){1'b0}}, word};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NT-1]) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/qstc_checker.sv =====
module qstc_assert
    import qstc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a result is either a word or four components, never both
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WORD_W-1:0] == '0) || (m_tdata[DATA_W-1:WORD_W] == '0))
        else $error("mixed compress and expand result");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled beat changed");

endmodule

bind quaternion_smallest_three_codec_unit qstc_assert u_qstc_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/qstc_checker.sv =====
module qstc_checker
    import qstc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                MAG_W = 9;
    localparam int                FRAC  = 14;
    localparam longint unsigned   MAGMAX = (64'd1 << MAG_W) - 64'd1;

    logic [DATA_W-1:0] beat_q[$];

    initial mismatches = 0;
    assign outstanding = beat_q.size();

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] smallest_three_pack(input int q[4]);
        int              big;
        int              ai;
        int              ab;
        logic            flip;
        logic            neg;
        logic [31:0]     word;
        longint unsigned a;
        longint unsigned p;
        longint unsigned mag;
        big = 0;
        for (int i = 1; i < 4; i++) begin
            ai = q[i] < 0 ? -q[i] : q[i];
            ab = q[big] < 0 ? -q[big] : q[big];
            if (ai > ab) big = i;
        end
        flip = q[big] < 0;
        word = 32'(big);
        for (int i = 0; i < 4; i++) begin
            if (i != big) begin
                a   = longint'(q[i] < 0 ? -q[i] : q[i]);
                neg = (q[i] < 0) != flip;
                p   = MAGMAX * a;
                mag = (int_root(64'd8 * p * p) + (64'd1 << FRAC)) >> (FRAC + 1);
                if (mag > MAGMAX) mag = MAGMAX;
                word = (word << FIELD_BITS) | (32'(neg) << SIGN_POS) | 32'(mag);
            end
        end
        return word;
    endfunction

    function automatic logic [4*COMP_W-1:0] smallest_three_unpack(input logic [31:0] w);
        int                 big;
        longint unsigned    m2;
        longint unsigned    sumsq;
        longint unsigned    mag;
        longint unsigned    v;
        longint unsigned    rem;
        logic               neg;
        logic [COMP_W-1:0]  q[4];
        big   = int'(w[31:30]);
        m2    = MAGMAX * MAGMAX;
        sumsq = 0;
        for (int i = 3; i >= 0; i--) begin
            if (i != big) begin
                mag   = longint'(w) & MAGMAX;
                neg   = w[SIGN_POS];
                w     = w >> FIELD_BITS;
                sumsq = sumsq + mag * mag;
                v = (int_root(((64'd2 * mag * mag) << (2 * FRAC)) / m2) + 1) >> 1;
                if (v > 32767) v = 32767;
                q[i] = neg ? -COMP_W'(v) : COMP_W'(v);
            end
        end
        rem = (2 * m2 > sumsq) ? 2 * m2 - sumsq : 0;
        v   = (int_root((rem << (2 * FRAC + 1)) / m2) + 1) >> 1;
        if (v > 32767) v = 32767;
        q[big] = COMP_W'(v);
        return {q[3], q[2], q[1], q[0]};
    endfunction

    function automatic logic [DATA_W-1:0] codec_result(input logic kind,
                                                       input logic [DATA_W-1:0] d);
        int q[4];
        if (kind == KIND_COMPRESS) begin
            for (int i = 0; i < 4; i++)
                q[i] = int'($signed(d[WORD_W + i*COMP_W +: COMP_W]));
            return {{4*COMP_W{1'b0}}, smallest_three_pack(q)};
        end
        return {smallest_three_unpack(d[WORD_W-1:0]), {WORD_W{1'b0}}};
    endfunction

    // handshake signals only change at rising edges, so the falling edge sees
    // exactly what the next rising edge will accept
    always @(negedge aclk) begin
        logic [DATA_W-1:0] want;
        logic              bad;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (beat_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end else begin
                    want = beat_q.pop_front();
                    bad  = 1'b0;
                    if (m_tdata[WORD_W-1:0] !== want[WORD_W-1:0]) bad = 1'b1;
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[WORD_W + i*COMP_W +: COMP_W] !==
                            want[WORD_W + i*COMP_W +: COMP_W]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch word exp %h got %h | abcd exp %h got %h",
                                     want[WORD_W-1:0], m_tdata[WORD_W-1:0],
                                     want[DATA_W-1:WORD_W], m_tdata[DATA_W-1:WORD_W]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                beat_q.push_back(codec_result(s_tuser, s_tdata));
        end
    end

endmodule

// ===== sim/tb_quaternion_smallest_three_codec_unit.sv =====
module tb_quaternion_smallest_three_codec_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import qstc_pkg::*;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tuser  = KIND_COMPRESS;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int send_idle = 26;
    int recv_idle = 82;
    int hold_ask  = 0;
    int hold_done = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    quaternion_smallest_three_codec_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    qstc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver: random stalls, or one long hold-off when asked
    always @(posedge aclk) begin
        if (hold_ask != hold_done) begin
            m_tready <= 1'b0;
            repeat (300) @(posedge aclk);
            hold_done = hold_ask;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(input logic kind, input logic [31:0] word,
                             input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] d);
        logic taken;
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {d, c, b, a, word};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        int r;
        r = $urandom_range(99);
        if (r < 4)  return 16'h8000;
        if (r < 8)  return 16'($urandom);
        if (r < 12) return 16'(16384);
        if (r < 16) return -16'(16384);
        if (r < 20) return 16'h0000;
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic random_beats(input int count);
        logic [15:0] c[4];
        logic [31:0] w;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 4; i++) c[i] = rand_comp();
            w = $urandom;
            if ($urandom_range(9) == 0) w[29:0] = {3{10'h1ff}};
            if ($urandom_range(1))
                send_beat(KIND_COMPRESS, w, c[0], c[1], c[2], c[3]);
            else
                send_beat(KIND_EXPAND, w, c[0], c[1], c[2], c[3]);
        end
    endtask

    initial begin
        #200000;
        $display("** quaternion_smallest_three_codec_unit: FAILED **");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ties, saturation
        send_beat(KIND_COMPRESS, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_COMPRESS, 32'h0, 16'd16384, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_COMPRESS, 32'h0, 16'd0, 16'd0, 16'd0, -16'd16384);
        send_beat(KIND_COMPRESS, 32'h0, 16'd8192, -16'd8192, 16'd8192, -16'd8192);
        send_beat(KIND_COMPRESS, 32'h0, -16'd8192, 16'd8192, -16'd8192, 16'd8192);
        send_beat(KIND_COMPRESS, 32'h0, 16'd11585, 16'd11585, 16'd0, 16'd0);
        send_beat(KIND_COMPRESS, 32'h0, 16'h8000, 16'd100, -16'd100, 16'd1);
        send_beat(KIND_COMPRESS, 32'h0, 16'd100, 16'h8000, 16'd16384, 16'h8000);
        send_beat(KIND_COMPRESS, 32'h0, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        send_beat(KIND_COMPRESS, 32'hffffffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(KIND_COMPRESS, 32'h0, -16'd1, 16'd1, -16'd1, 16'd0);
        send_beat(KIND_COMPRESS, 32'h0, 16'd8192, 16'd8192, 16'd8192, 16'd8192);
        send_beat(KIND_EXPAND, 32'h00000000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_beat(KIND_EXPAND, 32'h3fffffff, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'hc0000000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'h7fdff7fd, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'h9ff7fdff, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'h41f7c1f0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'h80000001, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'h1ff00000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(KIND_EXPAND, 32'hc01ffdff, 16'd0, 16'd0, 16'd0, 16'd0);
        random_beats(130);
        drain();

        send_idle = 82;
        recv_idle = 26;
        random_beats(130);
        drain();

        // no idling; long receiver hold-off fills the pipe
        send_idle = 0;
        recv_idle = 0;
        hold_ask  = hold_ask + 1;
        random_beats(130);
        drain();

        repeat (60) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** quaternion_smallest_three_codec_unit: PASSED **");
        end else begin
            $display("** quaternion_smallest_three_codec_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== quaternion_smallest_three_codec_unit.f =====
rtl/qstc_pkg.sv
rtl/quaternion_smallest_three_codec_unit.sv
rtl/qstc_checker.sv
sim/qstc_checker.sv
sim/tb_quaternion_smallest_three_codec_unit.sv
